/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the RTL, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/qtl_pkg.sv */
// ---------------------------------------------------------------------------
// qtl_pkg
// Types and constants shared by the quoted token lexer.
// ---------------------------------------------------------------------------
package qtl_pkg;

  localparam int QDEPTH = 4;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_TEND  = 3'd1,
    KIND_SLASH = 3'd2,
    KIND_ERR   = 3'd3,
    KIND_DONE  = 3'd4
  } kind_t;

  // work handed from front to back: optional held dash, optional byte, end
  typedef struct packed {
    logic       dash;
    logic       chr_v;
    logic [7:0] chr;
    logic       fin;
  } q_entry_t;

endpackage

/* rtl/core/quoted_token_lexer_line_comments.sv */
// ---------------------------------------------------------------------------
// quoted_token_lexer_line_comments
// Quote-aware tokenizer with "--" line comments, one text byte per request.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_ch (a text byte) and in_is_end
// (end of text; in_ch ignored). Output channel: out_valid/out_stall with
// out_kind (token char, token end, slash, unterminated quote, done),
// out_char and out_last, which flags the final result of one input request.
// A request that yields no result (comment bytes, held dash) is absorbed.
// The first result of a request passes through the queue entry, written
// when the request is taken, then the tokenizer output register.
// Throughput: one request per cycle while each yields at most one result
// and the receiver does not stall; a request yielding several results
// (at most 3) holds the output until each is taken, set by the single
// output register. Meanwhile the stripper keeps taking bytes into the
// QDEPTH-entry queue.
// When the receiver stalls, the current result holds; once the queue
// fills, in_stall rises. A synchronous low rst_n clears all quote, comment
// and token state and empties the queue. After an end request all state
// returns to reset, so a new stream may follow at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quoted_token_lexer_line_comments
  import qtl_pkg::*;
#(
  parameter int DEPTH = QDEPTH
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_is_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic     q_full, q_push, q_valid, q_pop;
  q_entry_t q_entry, q_head;

  qtl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch     (in_ch),
    .in_is_end (in_is_end),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  qtl_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  qtl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  // only token chars carry a character
  `ASSERT_IMP(a_char_zero, clk, rst_n, out_valid && out_kind != KIND_CHAR, out_char == 8'h00)
  // error and done close out their request
  `ASSERT_IMP(a_final_last, clk, rst_n, out_valid && (out_kind == KIND_ERR || out_kind == KIND_DONE), out_last)
  // only chars and token ends precede other results of the same request
  `ASSERT_IMP(a_mid_kind, clk, rst_n, out_valid && !out_last, out_kind == KIND_CHAR || out_kind == KIND_TEND)
  // a stream end with nothing stalled leaves no result behind
  `ASSERT_NXT(a_done_clear, clk, rst_n, out_valid && !out_stall && out_kind == KIND_DONE && !q_valid, !out_valid)

endmodule

/* rtl/core/qtl_front.sv */
// ---------------------------------------------------------------------------
// qtl_front
// Comment stripper: drops "--" line comments outside quotes, holds a dash.
// ---------------------------------------------------------------------------
module qtl_front
  import qtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_is_end,
  input  logic       q_full,
  output logic       q_push,
  output q_entry_t   q_entry
);

  typedef struct packed {
    logic in_q;
    logic q_dbl;
    logic dash;
    logic cmt;
    logic lhb;
  } strip_st_t;

  strip_st_t st_r, st_nxt;
  q_entry_t  ent;
  logic      accept;
  logic      go;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    st_nxt = st_r;
    ent    = '0;
    go     = 1'b0;
    if (in_is_end) begin
      ent.dash  = st_r.dash;
      ent.chr_v = st_r.lhb;
      ent.chr   = CH_NL;
      ent.fin   = 1'b1;
      st_nxt    = '0;
    end else if (in_ch == CH_NL) begin
      ent.dash  = st_r.dash;
      ent.chr_v = 1'b1;
      ent.chr   = CH_NL;
      st_nxt    = '0;
    end else begin
      st_nxt.lhb = 1'b1;
      if (!st_r.cmt) begin
        go = 1'b1;
        if (st_r.dash) begin
          st_nxt.dash = 1'b0;
          if (in_ch == CH_DASH) begin
            st_nxt.cmt = 1'b1;
            go         = 1'b0;
          end else begin
            ent.dash = 1'b1;
          end
        end
        if (go) begin
          if (in_ch == CH_SQ || in_ch == CH_DQ) begin
            if (!st_r.in_q) begin
              st_nxt.in_q  = 1'b1;
              st_nxt.q_dbl = (in_ch == CH_DQ);
            end else if (st_r.q_dbl == (in_ch == CH_DQ)) begin
              st_nxt.in_q = 1'b0;
            end
          end
          if (!st_nxt.in_q && in_ch == CH_DASH) begin
            st_nxt.dash = 1'b1;
          end else begin
            ent.chr_v = 1'b1;
            ent.chr   = in_ch;
          end
        end
      end
    end
  end

  assign q_entry = ent;
  assign q_push  = accept && (ent.dash || ent.chr_v || ent.fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* rtl/core/qtl_queue.sv */
// ---------------------------------------------------------------------------
// qtl_queue
// Small register queue decoupling the comment stripper from the tokenizer.
// ---------------------------------------------------------------------------
module qtl_queue
  import qtl_pkg::*;
#(
  parameter int DEPTH = QDEPTH
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/qtl_back.sv */
// ---------------------------------------------------------------------------
// qtl_back
// Tokenizer: splits stripped text into token results, one per cycle out unless the receiver stalls.
// ---------------------------------------------------------------------------
module qtl_back
  import qtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  q_entry_t   q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_char,
  output logic       out_last
);

  typedef struct packed {
    logic in_q;
    logic q_dbl;
    logic open;
  } tok_st_t;

  typedef struct packed {
    tok_st_t st;
    logic    tend;
    logic    slash;
    logic    chr;
  } tok_res_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] chr;
  } res_t;

  typedef struct packed {
    res_t [2:0] slot;
    logic [1:0] cnt;
  } rbuf_t;

  function automatic tok_res_t tok_byte(tok_st_t s, logic [7:0] c);
    tok_res_t r;
    logic     closes;
    r       = '0;
    r.st    = s;
    closes  = s.q_dbl ? (c == CH_DQ) : (c == CH_SQ);
    if (s.in_q) begin
      if (closes) begin
        r.tend    = s.open;
        r.st.open = 1'b0;
        r.st.in_q = 1'b0;
      end else begin
        r.chr     = 1'b1;
        r.st.open = 1'b1;
      end
    end else if (c == CH_SQ || c == CH_DQ) begin
      r.tend     = s.open;
      r.st.open  = 1'b0;
      r.st.in_q  = 1'b1;
      r.st.q_dbl = (c == CH_DQ);
    end else if (c == CH_SLASH) begin
      r.tend    = s.open;
      r.st.open = 1'b0;
      r.slash   = 1'b1;
    end else if (c == CH_SP || c == CH_TAB || c == CH_NL || c == CH_VT ||
                 c == CH_FF || c == CH_CR || c == CH_COMMA) begin
      r.tend    = s.open;
      r.st.open = 1'b0;
    end else begin
      r.chr     = 1'b1;
      r.st.open = 1'b1;
    end
    return r;
  endfunction

  function automatic rbuf_t add(rbuf_t b, logic en, kind_t k, logic [7:0] c);
    rbuf_t o;
    o = b;
    if (en && b.cnt != 2'd3) begin
      o.slot[b.cnt].kind = k;
      o.slot[b.cnt].chr  = c;
      o.cnt              = b.cnt + 2'd1;
    end
    return o;
  endfunction

  tok_st_t  tok_r, tok_nxt;
  rbuf_t    buf_r, buf_nxt;
  logic     valid_r;
  logic [1:0] ptr_r;
  tok_res_t r0, r1;
  tok_st_t  s1;
  logic     is_last, out_fire;

  always_comb begin
    buf_nxt = '0;
    r0      = tok_byte(tok_r, CH_DASH);
    s1      = q_head.dash ? r0.st : tok_r;
    r1      = tok_byte(s1, q_head.chr);
    tok_nxt = q_head.chr_v ? r1.st : s1;
    if (q_head.dash) begin
      buf_nxt = add(buf_nxt, r0.tend, KIND_TEND, 8'h00);
      buf_nxt = add(buf_nxt, r0.slash, KIND_SLASH, 8'h00);
      buf_nxt = add(buf_nxt, r0.chr, KIND_CHAR, CH_DASH);
    end
    if (q_head.chr_v) begin
      buf_nxt = add(buf_nxt, r1.tend, KIND_TEND, 8'h00);
      buf_nxt = add(buf_nxt, r1.slash, KIND_SLASH, 8'h00);
      buf_nxt = add(buf_nxt, r1.chr, KIND_CHAR, q_head.chr);
    end
    if (q_head.fin) begin
      if (tok_nxt.in_q) begin
        buf_nxt = add(buf_nxt, 1'b1, KIND_ERR, 8'h00);
      end else begin
        buf_nxt = add(buf_nxt, tok_nxt.open, KIND_TEND, 8'h00);
        buf_nxt = add(buf_nxt, 1'b1, KIND_DONE, 8'h00);
      end
      tok_nxt = '0;
    end
  end

  assign is_last   = (ptr_r == buf_r.cnt - 2'd1);
  assign out_fire  = valid_r && !out_stall;
  assign q_pop     = q_valid && (!valid_r || (out_fire && is_last));
  assign out_valid = valid_r;
  assign out_kind  = buf_r.slot[ptr_r].kind;
  assign out_char  = buf_r.slot[ptr_r].chr;
  assign out_last  = is_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      buf_r <= buf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      valid_r <= 1'b0;
      ptr_r   <= '0;
    end else if (q_pop) begin
      tok_r   <= tok_nxt;
      valid_r <= (buf_nxt.cnt != 2'd0);
      ptr_r   <= '0;
    end else if (out_fire) begin
      if (is_last) begin
        valid_r <= 1'b0;
      end else begin
        ptr_r <= ptr_r + 2'd1;
      end
    end
  end

endmodule

/* sim/token_stream_checker.sv */
// ----------------------------------------------------------------------------
// token_stream_checker
// Watches both channels of the quoted token lexer, predicts the result
// stream of every accepted request and compares each result field by field.
// ----------------------------------------------------------------------------
module token_stream_checker
  import qtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_is_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_kind,
  input  logic [7:0] out_char,
  input  logic       out_last,
  output int         mismatches,
  output int         pending,
  output int         checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] chr;
    logic       last;
  } lexeme_t;

  lexeme_t lexeme_q[$];
  lexeme_t step_q[$];
  lexeme_t want;

  // comment stripper
  bit s_quote;
  bit s_dq;
  bit dash_wait;
  bit skip_line;
  bit line_busy;
  // tokenizer
  bit t_quote;
  bit t_dq;
  bit tok_pending;

  task automatic clear_state();
    s_quote     = 1'b0;
    s_dq        = 1'b0;
    dash_wait   = 1'b0;
    skip_line   = 1'b0;
    line_busy   = 1'b0;
    t_quote     = 1'b0;
    t_dq        = 1'b0;
    tok_pending = 1'b0;
  endtask

  task automatic add_result(input kind_t k, input logic [7:0] c);
    lexeme_t r;
    r.kind = k;
    r.chr  = (k == KIND_CHAR) ? c : 8'h00;
    r.last = 1'b0;
    if (step_q.size() < 3) step_q = {step_q, r};
  endtask

  task automatic close_token();
    if (tok_pending) begin
      add_result(KIND_TEND, 8'h00);
      tok_pending = 1'b0;
    end
  endtask

  task automatic tok_byte(input logic [7:0] c);
    if (t_quote) begin
      if (t_dq ? (c == CH_DQ) : (c == CH_SQ)) begin
        close_token();
        t_quote = 1'b0;
      end else begin
        add_result(KIND_CHAR, c);
        tok_pending = 1'b1;
      end
    end else if (c == CH_SQ || c == CH_DQ) begin
      close_token();
      t_quote = 1'b1;
      t_dq    = (c == CH_DQ);
    end else if (c == CH_SLASH) begin
      close_token();
      add_result(KIND_SLASH, 8'h00);
    end else if (c inside {CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR, CH_COMMA}) begin
      close_token();
    end else begin
      add_result(KIND_CHAR, c);
      tok_pending = 1'b1;
    end
  endtask

  task automatic line_break();
    s_quote   = 1'b0;
    s_dq      = 1'b0;
    skip_line = 1'b0;
    line_busy = 1'b0;
    tok_byte(CH_NL);
  endtask

  task automatic flush_dash();
    if (dash_wait) begin
      dash_wait = 1'b0;
      tok_byte(CH_DASH);
    end
  endtask

  task automatic strip_byte(input logic [7:0] c);
    if (c == CH_NL) begin
      flush_dash();
      line_break();
      return;
    end
    line_busy = 1'b1;
    if (skip_line) return;
    if (dash_wait) begin
      dash_wait = 1'b0;
      if (c == CH_DASH) begin
        skip_line = 1'b1;
        return;
      end
      tok_byte(CH_DASH);
    end
    if (c == CH_SQ || c == CH_DQ) begin
      if (!s_quote) begin
        s_quote = 1'b1;
        s_dq    = (c == CH_DQ);
      end else if (s_dq == (c == CH_DQ)) begin
        s_quote = 1'b0;
      end
    end
    if (!s_quote && c == CH_DASH) begin
      dash_wait = 1'b1;
      return;
    end
    tok_byte(c);
  endtask

  task automatic predict_request(input logic [7:0] c, input logic fin);
    step_q.delete();
    if (!fin) begin
      strip_byte(c);
    end else begin
      flush_dash();
      if (line_busy) line_break();
      if (t_quote) begin
        add_result(KIND_ERR, 8'h00);
      end else begin
        close_token();
        add_result(KIND_DONE, 8'h00);
      end
      clear_state();
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    lexeme_q = {lexeme_q, step_q};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      lexeme_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (in_valid && !in_stall) predict_request(in_ch, in_is_end);
      if (out_valid && !out_stall) begin
        if (lexeme_q.size() == 0) begin
          $error("unexpected result: kind %0d char %02h last %0b",
                 out_kind, out_char, out_last);
          mismatches++;
        end else begin
          want = lexeme_q.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_kind);
            mismatches++;
          end
          if (out_char !== want.chr) begin
            $error("out_char: expected %02h, actual %02h", want.chr, out_char);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_last);
            mismatches++;
          end
          checked++;
        end
      end
    end
    pending = lexeme_q.size();
  end

endmodule

/* sim/tb_quoted_token_lexer_line_comments.sv */
// ----------------------------------------------------------------------------
// tb_quoted_token_lexer_line_comments
// Drives text streams into the quoted token lexer: a directed set of comment,
// quote, slash and end cases, then random streams of words, quoted strings,
// comments and stray bytes, with random idle and stall bursts on both sides.
// ----------------------------------------------------------------------------
module tb_quoted_token_lexer_line_comments
  import qtl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_REQUESTS = 150;
  localparam int CALM_TAIL      = 40;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } request_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_ch     = 8'h00;
  logic       in_is_end = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [2:0] out_kind;
  logic [7:0] out_char;
  logic       out_last;

  int mismatches;
  int pending;
  int checked;

  request_t text_q[$];
  int       streams    = 0;
  bit       calm       = 1'b0;
  int       cycles     = 0;
  int       stall_left = 0;

  quoted_token_lexer_line_comments dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch     (in_ch),
    .in_is_end (in_is_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  token_stream_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .in_is_end  (in_is_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_char   (out_char),
    .out_last   (out_last),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // random receiver stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && rst_n && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_byte(input logic [7:0] c);
    request_t rq;
    rq.ch  = c;
    rq.fin = 1'b0;
    text_q = {text_q, rq};
  endtask

  task automatic queue_end();
    request_t rq;
    rq.ch  = 8'($urandom_range(0, 255));
    rq.fin = 1'b1;
    text_q = {text_q, rq};
    streams++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'("a") + 8'($urandom_range(0, 25));
    if (r < 52) return 8'("0") + 8'($urandom_range(0, 9));
    if (r < 64) begin
      case ($urandom_range(0, 4))
        0: return CH_TAB;
        1: return CH_VT;
        2: return CH_FF;
        3: return CH_CR;
        default: return CH_SP;
      endcase
    end
    if (r < 70) return CH_COMMA;
    if (r < 76) return CH_SLASH;
    if (r < 83) return CH_DASH;
    if (r < 91) return CH_NL;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_random_stream(input int chunks);
    logic [7:0] q;
    int         r;
    for (int k = 0; k < chunks; k++) begin
      r = $urandom_range(0, 99);
      if (r < 58) begin
        queue_byte(plain_byte());
      end else if (r < 74) begin
        q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
        queue_byte(q);
        repeat ($urandom_range(0, 5)) queue_byte(plain_byte());
        queue_byte(q);
      end else if (r < 80) begin
        queue_byte($urandom_range(0, 1) ? CH_DQ : CH_SQ);
      end else if (r < 90) begin
        queue_byte(CH_DASH);
        queue_byte(CH_DASH);
        repeat ($urandom_range(0, 4)) queue_byte(plain_byte());
        queue_byte(CH_NL);
      end else begin
        queue_byte(CH_DASH);
        queue_byte(plain_byte());
      end
    end
    queue_end();
  endtask

  initial begin
    int directed;
    int idle;

    // directed: byte extremes, empty quotes, glued quotes, comment,
    // dash before newline, dash at end, unterminated quote
    queue_byte(8'h00);
    queue_text("a\"\"b'x'--z\n-q,/");
    queue_byte(8'hFF);
    queue_text("-\n-");
    queue_end();
    queue_text("\"u");
    queue_end();
    directed = text_q.size();

    while (text_q.size() < TOTAL_REQUESTS)
      queue_random_stream($urandom_range(3, 20));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (text_q[i]) begin
      if (i >= text_q.size() - CALM_TAIL) calm = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        idle = $urandom_range(1, 13);
        repeat (idle) @(negedge clk);
      end
      in_valid  <= 1'b1;
      in_ch     <= text_q[i].ch;
      in_is_end <= text_q[i].fin;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d requests in %0d text streams (%0d directed requests)",
             text_q.size(), streams, directed);
    $display("%0d results compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
